// ===== hdl/snpi_pkg.sv =====
// shared types, constants and the exp(-t) table of the normal area block
// no dependencies
package snpi_pkg;

  // sizes and formats
  localparam int MAX_INTERVALS   = 1024;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int LIMIT_FRAC_BITS = 12;
  localparam int TAYLOR_TERMS    = 26;

  localparam int LIM_W  = 16;
  localparam int CNT_W  = 11;
  localparam int AREA_W = 18;
  localparam int MAG_W  = AREA_W - 1;
  localparam int N_W    = $clog2(MAX_INTERVALS + 1);
  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_INTERVALS & ~1);
  localparam logic [MAG_W-1:0] AREA_MAX = MAG_W'(65536);

  // density path
  localparam int TI_W      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int TAB_W     = 31;
  localparam int SQ_W      = 2 * LIM_W - 1;
  localparam int SQ_SHIFT  = 2 * LIMIT_FRAC_BITS + 1 - 16;
  localparam int U_W       = SQ_W - SQ_SHIFT;
  localparam int P_W       = U_W + TI_W;
  localparam int IDX_SHIFT = 20;
  localparam int FR_SHIFT  = 4;
  localparam int FR_W      = 16;
  localparam int PH_W      = TAB_W + 32;
  localparam logic [31:0] INV_SQRT_2PI = 32'd1713444047;

  // accumulation and final scaling
  localparam int SUM_W     = N_W + 2 + TAB_W + 1;
  localparam int FIN_SHIFT = 14 + LIMIT_FRAC_BITS;
  localparam int FP_W      = SUM_W + LIM_W + 1;
  localparam int DIV_DW    = 32;
  localparam int DIV_SW    = N_W + 2;
  localparam int DIV_CW    = $clog2(DIV_DW + 1);

  // weight codes as left shifts: 1, 2, 4
  localparam logic [1:0] W_ONE  = 2'd0;
  localparam logic [1:0] W_TWO  = 2'd1;
  localparam logic [1:0] W_FOUR = 2'd2;

  typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

  // shift-subtract long division, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[63:0], num[b]};
      if (part >= {1'b0, dvs}) begin
        part   = part - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-k*16/depth) in Q30, built from a Taylor series of exp(-step)
  function automatic exp_tab_t build_exp_table();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] den;
    logic [63:0] step;
    logic [63:0] prev;
    exp_tab_t    tab;
    term = 64'd1 << 40;
    pos  = term;
    neg  = 64'd0;
    for (int j = 1; j < TAYLOR_TERMS; j++) begin
      den  = 64'(EXP_TABLE_DEPTH) * 64'(j);
      term = udiv64(term * 64'd16 + (den >> 1), den);
      if ((j & 1) != 0) neg = neg + term;
      else pos = pos + term;
    end
    step   = ((pos - neg) + (64'd1 << 7)) >> 8;
    prev   = 64'd1 << 30;
    tab[0] = TAB_W'(prev);
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      prev   = (prev * step + (64'd1 << 31)) >> 32;
      tab[k] = TAB_W'(prev);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_table();

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic pt_init;
    logic pt_step;
    logic fin_mul;
    logic res_load;
  } snpi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_bad;
    logic div_done;
    logic pt_last;
    logic pipe_busy;
    logic out_free;
  } snpi_stat_t;

endpackage

// ===== hdl/snpi_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on snpi_pkg
module snpi_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [snpi_pkg::DIV_DW-1:0]  dividend,
  input  logic [snpi_pkg::DIV_SW-1:0]  divisor,
  output logic [snpi_pkg::DIV_DW-1:0]  quot,
  output logic [snpi_pkg::DIV_SW-1:0]  rem,
  output logic                         done
);
  import snpi_pkg::*;

  logic [DIV_SW-1:0] dsr;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_SW:0]   trial;
  logic [DIV_SW:0]   diff;
  logic              ge;

  // one shift-subtract step
  assign trial = {rem, quot[DIV_DW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_DW-2:0], ge};
      rem  <= ge ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> (cnt != '0))
    else $error("divider busy with no steps left");

endmodule

// ===== hdl/snpi_datapath.sv =====
// point generator, density pipeline, accumulator, scaling and result register
// depends on snpi_pkg and snpi_div
module snpi_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  snpi_pkg::snpi_cmd_t               cmd,
  output snpi_pkg::snpi_stat_t              status,
  input  logic signed [snpi_pkg::LIM_W-1:0] lower_limit,
  input  logic signed [snpi_pkg::LIM_W-1:0] upper_limit,
  input  logic [snpi_pkg::CNT_W-1:0]        interval_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [snpi_pkg::AREA_W-1:0] area,
  output logic                              bad_count
);
  import snpi_pkg::*;

  // request registers
  logic signed [LIM_W-1:0] a;
  logic [LIM_W-1:0]        dmag;
  logic                    neg;
  logic                    bad;
  logic [N_W-1:0]          n;
  logic signed [LIM_W:0]   d;

  // divider
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_SW-1:0] div_divisor;
  logic [DIV_DW-1:0] quot;
  logic [DIV_SW-1:0] rem;
  logic              div_done;
  logic [DIV_SW-1:0] n3;
  logic [DIV_DW-1:0] fin;

  // point generator
  logic [LIM_W-1:0] q;
  logic [N_W-1:0]   r;
  logic [N_W-1:0]   i;
  logic [N_W:0]     r_sum;
  logic             wrap;
  logic [LIM_W-1:0] qd;
  logic [N_W-1:0]   rd;

  // pipeline
  logic signed [LIM_W+1:0] xs;
  logic signed [LIM_W-1:0] x16;
  logic [LIM_W-1:0]        xmag;
  logic [1:0]              w0;
  logic v1, v2, v3, v4;
  logic [SQ_W-1:0]  sq1;
  logic [1:0]       w1, w2, w3, w4;
  logic [U_W-1:0]   u;
  logic [P_W-1:0]   p;
  logic [P_W-1:0]   pidx;
  logic             ovf;
  logic [TI_W-1:0]  idx2;
  logic [FR_W-1:0]  frac2;
  logic             ovf2;
  logic [TAB_W-1:0] t0;
  logic [TAB_W-1:0] t1;
  logic [TAB_W+FR_W-1:0] prod;
  logic [TAB_W-1:0] t0_3;
  logic [TAB_W+FR_W-1:0] prod3;
  logic             ovf3;
  logic [TAB_W-1:0] e;
  logic [PH_W-1:0]  phm;
  logic [PH_W-1:0]  phm4;
  logic [TAB_W-1:0] ph;
  logic [SUM_W-1:0] sum;
  logic [FP_W-1:0]  fprod;
  logic [FP_W-1:0]  frnd;
  logic [MAG_W-1:0] mag;

  // request decode
  assign d = {upper_limit[LIM_W-1], upper_limit} - {lower_limit[LIM_W-1], lower_limit};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a    <= lower_limit;
      neg  <= d[LIM_W];
      dmag <= d[LIM_W] ? LIM_W'(-d) : d[LIM_W-1:0];
      bad  <= (interval_count == '0) || interval_count[0];
      if (interval_count > CNT_W'(MAX_INTERVALS)) n <= N_MAX;
      else n <= N_W'(interval_count);
    end
  end

  // shared divider: span over count, then scaled sum over 3n
  assign n3           = DIV_SW'({n, 1'b0}) + DIV_SW'(n);
  assign div_dividend = cmd.div_sel ? fin : DIV_DW'(dmag);
  assign div_divisor  = cmd.div_sel ? n3 : DIV_SW'(n);

  snpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  assign qd = quot[LIM_W-1:0];
  assign rd = rem[N_W-1:0];

  // sample offsets by quotient and remainder stepping
  assign r_sum = {1'b0, r} + {1'b0, rd};
  assign wrap  = r_sum >= {1'b0, n};

  always_ff @(posedge clk) begin
    if (cmd.pt_init) begin
      q <= '0;
      r <= n >> 1;
      i <= '0;
    end else if (cmd.pt_step) begin
      i <= i + 1'b1;
      q <= q + qd + LIM_W'(wrap);
      r <= wrap ? N_W'(r_sum - {1'b0, n}) : r_sum[N_W-1:0];
    end
  end

  // sample point, its magnitude and weight
  assign xs   = neg ? ({{2{a[LIM_W-1]}}, a} - {2'b00, q})
                    : ({{2{a[LIM_W-1]}}, a} + {2'b00, q});
  assign x16  = xs[LIM_W-1:0];
  assign xmag = x16[LIM_W-1] ? LIM_W'(-x16) : x16;
  assign w0   = ((i == '0) || (i == n)) ? W_ONE : (i[0] ? W_FOUR : W_TWO);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.pt_step;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: square
  always_ff @(posedge clk) begin
    sq1 <= SQ_W'(xmag) * SQ_W'(xmag);
    w1  <= w0;
  end

  // stage 2: table index and fraction
  assign u    = U_W'((sq1 + SQ_W'(1 << (SQ_SHIFT - 1))) >> SQ_SHIFT);
  assign p    = P_W'(u) * P_W'(EXP_TABLE_DEPTH);
  assign pidx = p >> IDX_SHIFT;
  assign ovf  = pidx >= P_W'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    idx2  <= ovf ? '0 : pidx[TI_W-1:0];
    frac2 <= p[FR_SHIFT+FR_W-1:FR_SHIFT];
    ovf2  <= ovf;
    w2    <= w1;
  end

  // stage 3: lookup and interpolation product
  assign t0   = EXP_TAB[idx2];
  assign t1   = EXP_TAB[idx2 + 1'b1];
  assign prod = (TAB_W+FR_W)'(t0 - t1) * (TAB_W+FR_W)'(frac2);

  always_ff @(posedge clk) begin
    t0_3  <= t0;
    prod3 <= prod;
    ovf3  <= ovf2;
    w3    <= w2;
  end

  // stage 4: exp value times 1/sqrt(2 pi)
  assign e   = ovf3 ? '0
             : t0_3 - TAB_W'((prod3 + (TAB_W+FR_W)'(1 << 15)) >> 16);
  assign phm = PH_W'(e) * PH_W'(INV_SQRT_2PI);

  always_ff @(posedge clk) begin
    phm4 <= phm;
    w4   <= w3;
  end

  // weighted accumulate
  assign ph = TAB_W'((phm4 + (PH_W'(1) << 31)) >> 32);

  always_ff @(posedge clk) begin
    if (cmd.pt_init) sum <= '0;
    else if (v4) sum <= sum + (SUM_W'(ph) << w4);
  end

  // scale by span, rounded, ahead of division by 3n
  assign fprod = FP_W'(sum) * FP_W'(dmag);
  assign frnd  = FP_W'(n3) << (FIN_SHIFT - 1);

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) fin <= DIV_DW'((fprod + frnd) >> FIN_SHIFT);
  end

  // result register
  assign mag = ((quot[DIV_DW-1:MAG_W] != '0) || (quot[MAG_W-1:0] > AREA_MAX))
             ? AREA_MAX : quot[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      bad_count <= bad;
      if (bad) area <= '0;
      else if (neg) area <= -$signed({1'b0, mag});
      else area <= $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.res_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // status
  assign status.in_bad    = (interval_count == '0) || interval_count[0];
  assign status.div_done  = div_done;
  assign status.pt_last   = i == n;
  assign status.pipe_busy = v1 | v2 | v3 | v4;
  assign status.out_free  = !out_valid || !out_stall;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_count) |-> (area == '0))
    else $error("bad count beat with nonzero area");
  a_area_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((area <= 18'sd65536) && (area >= -18'sd65536)))
    else $error("area beyond saturation bound");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> status.out_free)
    else $error("result overwrites a pending beat");

endmodule

// ===== hdl/snpi_ctrl.sv =====
// sequencer for one request: divide, sample sweep, drain, scale, divide, deliver; a bad count goes straight to deliver
// depends on snpi_pkg
module snpi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output snpi_pkg::snpi_cmd_t  cmd,
  input  snpi_pkg::snpi_stat_t status
);
  import snpi_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV1S = 3'd1;
  localparam logic [2:0] ST_DIV1W = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_DIV2W = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = state != ST_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_bad ? ST_FIN : ST_DIV1S;
        end
      end
      ST_DIV1S: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV1W;
      end
      ST_DIV1W: begin
        if (status.div_done) begin
          cmd.pt_init = 1'b1;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.pt_step = 1'b1;
        if (status.pt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.fin_mul = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = ST_DIV2W;
      end
      ST_DIV2W: begin
        if (status.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input taken again right after a beat");
  a_scale_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> $past(!status.pipe_busy))
    else $error("scaling started with samples in flight");
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (state == ST_IDLE))
    else $error("sequencer not idle after delivering a result");

endmodule

// ===== hdl/simpson_normal_pdf_integrator.sv =====
// standard normal area over [lower, upper] by composite simpson rule
// for an even count n (clamped to 1024) the result follows a sweep of one sample a cycle
//   through the density pipeline and two divider passes
// one request at a time: a new beat is taken once the last result is delivered; a zero or odd
//   count skips the divider and the sweep and goes straight to the result register
// reset (synchronous, active high) empties the sequencer, pipeline and result register
// depends on snpi_pkg, snpi_ctrl, snpi_datapath, snpi_div
module simpson_normal_pdf_integrator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [snpi_pkg::LIM_W-1:0]  lower_limit,
  input  logic signed [snpi_pkg::LIM_W-1:0]  upper_limit,
  input  logic [snpi_pkg::CNT_W-1:0]         interval_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [snpi_pkg::AREA_W-1:0] area,
  output logic                               bad_count
);
  import snpi_pkg::*;

  snpi_cmd_t  cmd;
  snpi_stat_t status;

  snpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  snpi_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .lower_limit    (lower_limit),
    .upper_limit    (upper_limit),
    .interval_count (interval_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .area           (area),
    .bad_count      (bad_count)
  );

endmodule
